// ----- rtl/bar_pkg.sv -----
package bar_pkg;

	localparam int NUM_VALUES   = 256;
	localparam int BYTE_W       = 8;
	localparam int COUNT_W      = 9;
	localparam int CFG_ADDR_W   = 3;
	localparam int CFG_DATA_W   = 32;

	localparam logic [BYTE_W-1:0] MIN_CODE_RESET = 8'd2;

	// register index taken from paddr[2]
	localparam logic REG_MIN_VALID_CODE = 1'b0;

	typedef struct packed {
		logic              action;
		logic [BYTE_W-1:0] in_byte;
		logic              last;
	} in_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  out_byte;
		logic [COUNT_W-1:0] alphabet_size;
		logic               remap_active;
		logic               too_many_symbols;
		logic               pass_done;
	} out_t;

	typedef struct packed {
		logic capture;
		logic set_presence;
		logic clear_presence;
		logic ram_re;
		logic count_init;
		logic count_step;
		logic eval;
		logic walk_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic count_last;
		logic remap_go;
		logic walk_done;
		logic out_free;
	} sts_t;

endpackage

// ----- rtl/bar_ram.sv -----
module bar_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/bar_ctrl.sv -----
module bar_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          item_valid,
	input  logic          item_action,
	input  logic          item_last,
	output logic          item_stall,
	input  bar_pkg::sts_t sts,
	output bar_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_EVAL,
		ST_WALK,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && (state_q == ST_IDLE);

	always_comb begin
		cmd                = '0;
		cmd.capture        = accept;
		cmd.set_presence   = accept && !item_action;
		cmd.clear_presence = accept && item_action && item_last;
		cmd.ram_re         = accept && item_action;
		cmd.count_init     = accept && !item_action && item_last;
		case (state_q)
			ST_COUNT: cmd.count_step = 1'b1;
			ST_EVAL:  cmd.eval       = 1'b1;
			ST_WALK:  cmd.walk_step  = !sts.walk_done;
			ST_EMIT:  cmd.out_load   = sts.out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (!item_action && item_last) ? ST_COUNT : ST_EMIT;
					end
				end
				ST_COUNT: begin
					if (sts.count_last) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					state_q <= sts.remap_go ? ST_WALK : ST_EMIT;
				end
				ST_WALK: begin
					if (sts.walk_done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.count_init |=> state_q == ST_COUNT)
		else $error("last scan beat did not start the count sweep");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> $past(state_q) == ST_EVAL || $past(state_q) == ST_WALK)
		else $error("walk step outside of map build");

endmodule

// ----- rtl/bar_dp.sv -----
module bar_dp (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bar_pkg::cmd_t               cmd,
	input  bar_pkg::in_t                item,
	input  logic [bar_pkg::BYTE_W-1:0]  min_code,
	output bar_pkg::sts_t               sts,
	output bar_pkg::out_t               result,
	output logic                        result_valid,
	input  logic                        result_stall
);

	localparam int IDX_W = $clog2(bar_pkg::NUM_VALUES);

	logic [bar_pkg::NUM_VALUES-1:0] presence_q;

	logic                          action_q;
	logic [bar_pkg::BYTE_W-1:0]    byte_q;
	logic                          last_q;

	logic [IDX_W-1:0]              cnt_q;
	logic [bar_pkg::COUNT_W-1:0]   distinct_q;
	logic                          low_q;

	logic [bar_pkg::COUNT_W-1:0]   symbol_q;
	logic                          remap_q;
	logic                          err_q;
	logic [bar_pkg::BYTE_W-1:0]    lrv_q;

	logic [IDX_W:0]                walk_q;
	logic [IDX_W:0]                next_code_q;

	logic                          cnt_bit;
	logic [bar_pkg::COUNT_W-1:0]   sum;
	logic                          too_many;
	logic [IDX_W-1:0]              walk_idx;
	logic                          walk_bit;
	logic [bar_pkg::BYTE_W-1:0]    ram_wdata;
	logic [bar_pkg::BYTE_W-1:0]    ram_rdata;
	logic [bar_pkg::BYTE_W-1:0]    mapped;
	bar_pkg::out_t                 next_out;

	assign cnt_bit  = presence_q[cnt_q];
	assign sum      = distinct_q + 9'd1;
	assign too_many = low_q && ({1'b0, sum} >
		(10'(bar_pkg::NUM_VALUES) - {2'b00, min_code}));
	assign walk_idx = walk_q[IDX_W-1:0];
	assign walk_bit = presence_q[walk_idx];
	assign ram_wdata = walk_bit ? next_code_q[bar_pkg::BYTE_W-1:0] : '0;

	assign sts.count_last = (cnt_q == IDX_W'(bar_pkg::NUM_VALUES - 1));
	assign sts.remap_go   = low_q && !too_many;
	assign sts.walk_done  = walk_q[IDX_W] || (walk_q >= next_code_q);
	assign sts.out_free   = !result_valid || !result_stall;

	bar_ram #(
		.WIDTH(bar_pkg::BYTE_W),
		.DEPTH(bar_pkg::NUM_VALUES)
	) u_code_table (
		.clk  (clk),
		.we   (cmd.walk_step),
		.waddr(walk_idx),
		.wdata(ram_wdata),
		.re   (cmd.ram_re),
		.raddr(item.in_byte),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			presence_q <= '0;
		end else if (cmd.clear_presence) begin
			presence_q <= '0;
		end else if (cmd.set_presence) begin
			presence_q[item.in_byte] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			action_q <= item.action;
			byte_q   <= item.in_byte;
			last_q   <= item.last;
		end
	end

	// presence sweep
	always_ff @(posedge clk) begin
		if (cmd.count_init) begin
			cnt_q      <= '0;
			distinct_q <= '0;
			low_q      <= 1'b0;
		end else if (cmd.count_step) begin
			cnt_q      <= cnt_q + IDX_W'(1);
			distinct_q <= distinct_q + 9'(cnt_bit);
			low_q      <= low_q || (cnt_bit && (cnt_q < min_code));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			symbol_q <= 9'd1;
			remap_q  <= 1'b0;
			err_q    <= 1'b0;
			lrv_q    <= '0;
		end else if (cmd.eval) begin
			symbol_q <= sum;
			remap_q  <= low_q && !too_many;
			err_q    <= too_many;
			lrv_q    <= '0;
		end else if (cmd.walk_step && walk_bit) begin
			lrv_q <= walk_idx;
		end
	end

	// map build walk
	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			walk_q      <= '0;
			next_code_q <= {1'b0, min_code};
		end else if (cmd.walk_step) begin
			walk_q <= walk_q + (IDX_W+1)'(1);
			if (walk_bit) begin
				next_code_q <= next_code_q + (IDX_W+1)'(1);
			end
		end
	end

	assign mapped = (remap_q && (byte_q <= lrv_q)) ? ram_rdata : byte_q;

	always_comb begin
		next_out.out_byte         = action_q ? mapped : byte_q;
		next_out.alphabet_size    = symbol_q;
		next_out.remap_active     = remap_q;
		next_out.too_many_symbols = err_q;
		next_out.pass_done        = last_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (cmd.out_load) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			result <= next_out;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(remap_q && err_q))
		else $error("map active together with error flag");

	assert property (@(posedge clk) disable iff (!arst_n)
		!remap_q |-> lrv_q == '0)
		else $error("largest remapped value set without a map");

	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.walk_step && walk_bit) |-> ram_wdata >= min_code)
		else $error("code written below the minimum valid code");

	assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> sts.out_free)
		else $error("result register overwritten while stalled");

endmodule

// ----- rtl/byte_alphabet_remapper_unit.sv -----
// scan beats and remap beats: captured on accept, then loaded into the result register in the emit state
// last scan beat: presence sweep over all 256 values, an evaluate step, then a map walk over the values
//   (at most 255 visited) only when a map is built, then the emit state loads the result
// result register decouples output stall; next beat is taken while a result waits
// reset: presence map, alphabet size (one), flags and min_valid_code (2) reset at once
// code table ram holds no reset value and gets no clearing pass
module byte_alphabet_remapper_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [bar_pkg::CFG_ADDR_W-1:0]    paddr,
	input  logic [bar_pkg::CFG_DATA_W-1:0]    pwdata,
	output logic [bar_pkg::CFG_DATA_W-1:0]    prdata,
	output logic                              pready,
	input  logic                              item_valid,
	output logic                              item_stall,
	input  bar_pkg::in_t                      item,
	output logic                              result_valid,
	input  logic                              result_stall,
	output bar_pkg::out_t                     result
);

	logic [bar_pkg::BYTE_W-1:0] min_code_q;
	bar_pkg::cmd_t              cmd;
	bar_pkg::sts_t              sts;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_code_q <= bar_pkg::MIN_CODE_RESET;
		end else if (psel && penable && pwrite
			&& (paddr[2] == bar_pkg::REG_MIN_VALID_CODE)) begin
			min_code_q <= pwdata[bar_pkg::BYTE_W-1:0];
		end
	end

	assign prdata = (paddr[2] == bar_pkg::REG_MIN_VALID_CODE)
		? {{(bar_pkg::CFG_DATA_W-bar_pkg::BYTE_W){1'b0}}, min_code_q} : '0;

	bar_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_action(item.action),
		.item_last  (item.last),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	bar_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.item        (item),
		.min_code    (min_code_q),
		.sts         (sts),
		.result      (result),
		.result_valid(result_valid),
		.result_stall(result_stall)
	);

endmodule
